>>> hw/rtl/rcpt_pkg.sv
`default_nettype none

package rcpt_pkg;

    // Item modes
    localparam logic [1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [1:0] MODE_ENABLE  = 2'd1;
    localparam logic [1:0] MODE_DISABLE = 2'd2;

    // Register indexes (word address bit 2)
    localparam logic [0:0] REG_CHARGE_THR    = 1'b0;
    localparam logic [0:0] REG_DISCHARGE_THR = 1'b1;

    localparam int THR_W = 12;
    localparam logic [THR_W-1:0] CHARGE_THR_RST    = 12'd2100;
    localparam logic [THR_W-1:0] DISCHARGE_THR_RST = 12'd800;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  channel;
        logic [11:0] sample_mv;
    } sample_t;

    typedef struct packed {
        logic [2:0]  channel_out;
        logic        is_active;
        logic        next_charging;
        logic        switched;
        logic [11:0] filtered_mv;
        logic [31:0] reading;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic scale;
        logic load_out;
    } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/rcpt_ram.sv
`default_nettype none

module rcpt_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rcpt_ctrl.sv
`default_nettype none

module rcpt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          sample_valid,
    output logic               sample_ready,
    output logic               result_valid,
    input  wire logic          result_ready,
    output rcpt_pkg::cmd_t     cmd
);

    rcpt_pkg::state_t state_reg;
    rcpt_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result_ready;
        sample_ready   = 1'b0;
        cmd            = '0;
        case (state_reg)
            rcpt_pkg::ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = rcpt_pkg::ST_UPDATE;
                end
            end
            rcpt_pkg::ST_UPDATE:
            begin
                cmd.commit = 1'b1;
                state_next = rcpt_pkg::ST_SCALE;
            end
            rcpt_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = rcpt_pkg::ST_DONE;
            end
            rcpt_pkg::ST_DONE:
            begin
                // hold here until the output register can take the beat
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    sample_ready   = 1'b1;
                    if (sample_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = rcpt_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        state_next = rcpt_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rcpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/rcpt_dp.sv
`default_nettype none

module rcpt_dp #(
    parameter int NUM_CHANNELS = 8,
    parameter int WINDOW_DEPTH = 256,
    parameter int SAMPLE_BITS  = 12,
    parameter int COUNT_BITS   = 32,
    parameter int CH_W         = 3,
    parameter int POS_W        = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire rcpt_pkg::cmd_t             cmd,
    input  wire rcpt_pkg::sample_t          sample,
    input  wire logic [rcpt_pkg::THR_W-1:0] charge_thr,
    input  wire logic [rcpt_pkg::THR_W-1:0] discharge_thr,
    output logic                            ram_re,
    output logic [CH_W+POS_W-1:0]           ram_raddr,
    input  wire logic [SAMPLE_BITS-1:0]     ram_rdata,
    output logic                            ram_we,
    output logic [CH_W+POS_W-1:0]           ram_waddr,
    output logic [SAMPLE_BITS-1:0]          ram_wdata,
    output rcpt_pkg::result_t               result
);

    localparam int SUM_W   = SAMPLE_BITS + POS_W;
    localparam int CMP_W   = SUM_W + 5;
    localparam int SHIFT   = SUM_W + POS_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // floor(2^SHIFT / depth) + 1 gives an exact quotient for any SUM_W-bit sum
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) / 64'(WINDOW_DEPTH)) + 64'd1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(WINDOW_DEPTH);
    localparam logic [6:0]       NUM_CH_C = 7'(NUM_CHANNELS);

    function automatic logic [COUNT_BITS-1:0] half_sum(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b
    );
        return (a >> 1) + (b >> 1) + COUNT_BITS'(a[0] & b[0]);
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    // captured item
    logic [1:0]             mode_reg;
    logic [2:0]             chan_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [CH_W-1:0]        idx_reg;
    logic                   ok_reg;

    // per-channel state
    logic                  active_reg   [NUM_CHANNELS];
    logic                  charging_reg [NUM_CHANNELS];
    logic                  fill_reg     [NUM_CHANNELS];
    logic [POS_W-1:0]      pos_reg      [NUM_CHANNELS];
    logic [SUM_W-1:0]      sum_reg      [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] ccnt_reg     [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] dcnt_reg     [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] cmean_reg    [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] dmean_reg    [NUM_CHANNELS];

    // result snapshot and scaling
    logic [2:0]            res_ch_reg;
    logic                  res_active_reg;
    logic                  res_charging_reg;
    logic                  res_sw_reg;
    logic [SUM_W-1:0]      res_sum_reg;
    logic [COUNT_BITS-1:0] res_cmean_reg;
    logic [COUNT_BITS-1:0] res_dmean_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [31:0]           reading_reg;
    rcpt_pkg::result_t     result_reg;

    logic [CH_W-1:0]       in_idx;
    logic                  cur_active;
    logic                  cur_charging;
    logic                  cur_fill;
    logic [POS_W-1:0]      cur_pos;
    logic [SUM_W-1:0]      cur_sum;
    logic [COUNT_BITS-1:0] cur_ccnt;
    logic [COUNT_BITS-1:0] cur_dcnt;
    logic [COUNT_BITS-1:0] cur_cmean;
    logic [COUNT_BITS-1:0] cur_dmean;

    logic [SAMPLE_BITS-1:0] old_smp;
    logic [SUM_W-1:0]       sum_upd;
    logic                   pos_wrap;
    logic [COUNT_BITS-1:0]  ccnt_inc;
    logic [COUNT_BITS-1:0]  dcnt_inc;
    logic                   hit_charge;
    logic                   hit_discharge;
    logic                   do_clear;
    logic                   do_step;

    logic                  n_active;
    logic                  n_charging;
    logic                  n_fill;
    logic [POS_W-1:0]      n_pos;
    logic [SUM_W-1:0]      n_sum;
    logic [COUNT_BITS-1:0] n_ccnt;
    logic [COUNT_BITS-1:0] n_dcnt;
    logic [COUNT_BITS-1:0] n_cmean;
    logic [COUNT_BITS-1:0] n_dmean;
    logic                  n_sw;

    assign in_idx    = CH_W'(sample.channel);
    assign ram_re    = cmd.capture;
    assign ram_raddr = {in_idx, pos_reg[in_idx]};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= sample.mode;
            chan_reg <= sample.channel;
            smp_reg  <= SAMPLE_BITS'(sample.sample_mv);
            idx_reg  <= in_idx;
            ok_reg   <= (7'(sample.channel) < NUM_CH_C);
        end
    end

    assign cur_active   = active_reg[idx_reg];
    assign cur_charging = charging_reg[idx_reg];
    assign cur_fill     = fill_reg[idx_reg];
    assign cur_pos      = pos_reg[idx_reg];
    assign cur_sum      = sum_reg[idx_reg];
    assign cur_ccnt     = ccnt_reg[idx_reg];
    assign cur_dcnt     = dcnt_reg[idx_reg];
    assign cur_cmean    = cmean_reg[idx_reg];
    assign cur_dmean    = dmean_reg[idx_reg];

    // a slot not yet written since the channel was cleared reads as zero
    assign old_smp       = cur_fill ? ram_rdata : '0;
    assign sum_upd       = cur_sum - SUM_W'(old_smp) + SUM_W'(smp_reg);
    assign pos_wrap      = (cur_pos == POS_LAST);
    assign ccnt_inc      = sat_inc(cur_ccnt);
    assign dcnt_inc      = sat_inc(cur_dcnt);
    assign hit_charge    = CMP_W'(sum_upd) >= CMP_W'(charge_thr) * DEPTH_C;
    assign hit_discharge = CMP_W'(sum_upd) <= CMP_W'(discharge_thr) * DEPTH_C;
    assign do_clear      = ok_reg && ((mode_reg == rcpt_pkg::MODE_ENABLE) ||
                                      (mode_reg == rcpt_pkg::MODE_DISABLE));
    assign do_step       = ok_reg && (mode_reg == rcpt_pkg::MODE_SAMPLE) && cur_active;

    always_comb
    begin
        n_active   = cur_active;
        n_charging = cur_charging;
        n_fill     = cur_fill;
        n_pos      = cur_pos;
        n_sum      = cur_sum;
        n_ccnt     = cur_ccnt;
        n_dcnt     = cur_dcnt;
        n_cmean    = cur_cmean;
        n_dmean    = cur_dmean;
        n_sw       = 1'b0;
        if (do_clear)
        begin
            n_active   = (mode_reg == rcpt_pkg::MODE_ENABLE);
            n_charging = 1'b0;
            n_fill     = 1'b0;
            n_pos      = '0;
            n_sum      = '0;
            n_ccnt     = '0;
            n_dcnt     = '0;
            n_cmean    = '0;
            n_dmean    = '0;
        end
        else if (do_step)
        begin
            n_sum  = sum_upd;
            n_pos  = pos_wrap ? '0 : cur_pos + POS_W'(1);
            n_fill = cur_fill || pos_wrap;
            if (cur_charging)
            begin
                if (hit_charge)
                begin
                    n_charging = 1'b0;
                    n_cmean    = half_sum(cur_cmean, ccnt_inc);
                    n_ccnt     = '0;
                    n_sw       = 1'b1;
                end
                else
                begin
                    n_ccnt = ccnt_inc;
                end
            end
            else
            begin
                if (hit_discharge)
                begin
                    n_charging = 1'b1;
                    n_dmean    = half_sum(cur_dmean, dcnt_inc);
                    n_dcnt     = '0;
                    n_sw       = 1'b1;
                end
                else
                begin
                    n_dcnt = dcnt_inc;
                end
            end
        end
    end

    assign ram_we    = cmd.commit && do_step;
    assign ram_waddr = {idx_reg, cur_pos};
    assign ram_wdata = smp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                active_reg[i]   <= 1'b0;
                charging_reg[i] <= 1'b0;
                fill_reg[i]     <= 1'b0;
                pos_reg[i]      <= '0;
                sum_reg[i]      <= '0;
                ccnt_reg[i]     <= '0;
                dcnt_reg[i]     <= '0;
                cmean_reg[i]    <= '0;
                dmean_reg[i]    <= '0;
            end
        end
        else if (cmd.commit && ok_reg)
        begin
            active_reg[idx_reg]   <= n_active;
            charging_reg[idx_reg] <= n_charging;
            fill_reg[idx_reg]     <= n_fill;
            pos_reg[idx_reg]      <= n_pos;
            sum_reg[idx_reg]      <= n_sum;
            ccnt_reg[idx_reg]     <= n_ccnt;
            dcnt_reg[idx_reg]     <= n_dcnt;
            cmean_reg[idx_reg]    <= n_cmean;
            dmean_reg[idx_reg]    <= n_dmean;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_ch_reg       <= chan_reg;
            res_active_reg   <= ok_reg && n_active;
            res_charging_reg <= ok_reg && n_charging;
            res_sw_reg       <= n_sw;
            res_sum_reg      <= ok_reg ? n_sum : '0;
            res_cmean_reg    <= ok_reg ? n_cmean : '0;
            res_dmean_reg    <= ok_reg ? n_dmean : '0;
        end
        if (cmd.scale)
        begin
            prod_reg    <= PROD_W'(res_sum_reg) * PROD_W'(RECIP);
            reading_reg <= res_active_reg ? 32'(half_sum(res_cmean_reg, res_dmean_reg))
                                          : 32'd0;
        end
        if (cmd.load_out)
        begin
            result_reg.channel_out   <= res_ch_reg;
            result_reg.is_active     <= res_active_reg;
            result_reg.next_charging <= res_charging_reg;
            result_reg.switched      <= res_sw_reg;
            result_reg.filtered_mv   <= 12'(prod_reg >> SHIFT);
            result_reg.reading       <= reading_reg;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rc_pulse_adc_channel_tracker_unit.sv
// Per-channel charge-time ADC tracker with a moving-average window.
// Input channel (sample_valid / sample_ready / sample): one beat per pulse.
// Mode sample on an enabled channel feeds the reading into its window ring;
// mode enable or disable clears the channel, ring included. Output channel
// (result_valid / result_ready / result): exactly one beat per input beat.
// Items are handled one at a time: the window RAM read, the state update
// with the RAM write-back, and the multiply that scales the window sum to
// millivolts run in turn for each item.
// A finished result sits in the output register; the next item is taken in
// while it waits. If the receiver stalls, the item after that holds in its
// last step until the output register frees, and sample_ready stays low.
// Reset clears all channel state and loads the threshold reset values. The
// ring RAM needs no clearing pass: a per-channel fill flag makes slots not
// yet written since the last clear read as zero, so items are taken at once.
// Thresholds are written over the APB port (0x0 charge, 0x4 discharge). The
// user must write them while no item is in flight: not enforced by the block.
`default_nettype none

module rc_pulse_adc_channel_tracker_unit #(
    parameter int NUM_CHANNELS = 8,
    parameter int WINDOW_DEPTH = 256,
    parameter int SAMPLE_BITS  = 12,
    parameter int COUNT_BITS   = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              sample_valid,
    output logic                   sample_ready,
    input  wire rcpt_pkg::sample_t sample,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output rcpt_pkg::result_t      result
);

    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int POS_W   = $clog2(WINDOW_DEPTH);
    localparam int RAM_AW  = CH_W + POS_W;
    localparam int RAM_DEP = 1 << RAM_AW;

    logic [rcpt_pkg::THR_W-1:0] charge_thr_reg;
    logic [rcpt_pkg::THR_W-1:0] discharge_thr_reg;
    logic                       cfg_write;

    rcpt_pkg::cmd_t             cmd;
    logic                       ram_re;
    logic [RAM_AW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0]     ram_rdata;
    logic                       ram_we;
    logic [RAM_AW-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0]     ram_wdata;

    // Configuration: always ready, write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_thr_reg    <= rcpt_pkg::CHARGE_THR_RST;
            discharge_thr_reg <= rcpt_pkg::DISCHARGE_THR_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2:2])
                rcpt_pkg::REG_CHARGE_THR:
                begin
                    charge_thr_reg <= pwdata[rcpt_pkg::THR_W-1:0];
                end
                rcpt_pkg::REG_DISCHARGE_THR:
                begin
                    discharge_thr_reg <= pwdata[rcpt_pkg::THR_W-1:0];
                end
                default:
                begin
                    charge_thr_reg <= charge_thr_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2:2])
            rcpt_pkg::REG_CHARGE_THR:    prdata = 32'(charge_thr_reg);
            rcpt_pkg::REG_DISCHARGE_THR: prdata = 32'(discharge_thr_reg);
            default:                     prdata = 32'd0;
        endcase
    end

    // Sequencer: capture, update, scale, then hand the beat to the output
    rcpt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    // Channel state, window arithmetic and output register
    rcpt_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COUNT_BITS   (COUNT_BITS),
        .CH_W         (CH_W),
        .POS_W        (POS_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sample        (sample),
        .charge_thr    (charge_thr_reg),
        .discharge_thr (discharge_thr_reg),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .result        (result)
    );

    // Window rings of all channels, one row of slots per channel
    rcpt_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEP)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One item in flight: no new beat right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("beat accepted while previous item still in progress");

    // Ring write-back happens only in the cycle after an item is taken
    a_ram_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> $past(sample_valid && sample_ready))
        else $error("ring write outside the update step");

    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_valid || result_ready))
        else $error("output register loaded while holding an untaken beat");

endmodule

`default_nettype wire

>>> dv/rc_pulse_adc_channel_tracker_unit_tb.sv
module rc_pulse_adc_channel_tracker_unit_tb;

    // Mode 3 is left unused by the block; keep a name for it here.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int CHANNELS       = 8;
    localparam int RING_DEPTH     = 256;
    // Idle time after the last result, to let the block settle.
    localparam int SETTLE_CYCLES  = 8;
    // Long receiver hold-off used to fill the block and stall its input.
    localparam int LONG_STALL     = 300;
    // Cycles with no beat and no register write before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    // ------------------------------------------------------------------
    // Clock, reset and the driven inputs, all known from time zero
    // ------------------------------------------------------------------
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [2:0]         paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic               sample_valid = 1'b0;
    rcpt_pkg::sample_t  sample       = '0;
    logic               result_ready = 1'b0;

    logic [31:0]        prdata;
    logic               pready;
    logic               sample_ready;
    logic               result_valid;
    rcpt_pkg::result_t  result;

    always #5 clk = ~clk;

    rc_pulse_adc_channel_tracker_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // ------------------------------------------------------------------
    // Shared run control
    // ------------------------------------------------------------------
    int                fail_count    = 0;
    int                quiet_cycles  = 0;
    bit                calm          = 1'b0;   // no idling on either side while set
    bit                stall_request = 1'b0;   // ask the result sink for one long hold-off
    rcpt_pkg::result_t pending_results[$];     // predicted results, oldest first

    // ------------------------------------------------------------------
    // Tracker state as the testbench sees it
    // ------------------------------------------------------------------
    logic        chg_phase [CHANNELS];   // 1 charging, 0 discharging
    logic        chan_on   [CHANNELS];
    logic [31:0] chg_count [CHANNELS];
    logic [31:0] dis_count [CHANNELS];
    logic [31:0] chg_avg   [CHANNELS];
    logic [31:0] dis_avg   [CHANNELS];
    logic [11:0] ring_mem  [CHANNELS][RING_DEPTH];
    logic [7:0]  ring_wr   [CHANNELS];
    logic [19:0] win_sum   [CHANNELS];
    logic [11:0] thr_charge;
    logic [11:0] thr_discharge;

    // Floor of (a + b) / 2 without a carry out of 32 bits.
    function automatic logic [31:0] floor_avg(input logic [31:0] a, input logic [31:0] b);
        return {1'b0, a[31:1]} + {1'b0, b[31:1]} + {31'b0, a[0] & b[0]};
    endfunction

    // Count up, stick at all ones.
    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    task automatic wipe_channel(input int ch);
        chg_phase[ch] = 1'b0;
        chan_on[ch]   = 1'b0;
        chg_count[ch] = '0;
        dis_count[ch] = '0;
        chg_avg[ch]   = '0;
        dis_avg[ch]   = '0;
        ring_wr[ch]   = '0;
        win_sum[ch]   = '0;
        for (int i = 0; i < RING_DEPTH; i++)
            ring_mem[ch][i] = '0;
    endtask

    // Apply one accepted beat to the tracker state and build its result.
    task automatic track_channel(input rcpt_pkg::sample_t beat,
                                 output rcpt_pkg::result_t want);
        int          ch;
        logic [7:0]  pos;
        logic        flip;
        ch   = beat.channel;
        flip = 1'b0;
        if (beat.mode == rcpt_pkg::MODE_ENABLE || beat.mode == rcpt_pkg::MODE_DISABLE)
        begin
            wipe_channel(ch);
            chan_on[ch] = (beat.mode == rcpt_pkg::MODE_ENABLE);
        end
        else if (beat.mode == rcpt_pkg::MODE_SAMPLE && chan_on[ch])
        begin
            pos = ring_wr[ch];
            if (chg_phase[ch])
                chg_count[ch] = bump(chg_count[ch]);
            else
                dis_count[ch] = bump(dis_count[ch]);
            // The sum always holds the slot being replaced, so this never wraps.
            win_sum[ch]       = win_sum[ch] - ring_mem[ch][pos] + beat.sample_mv;
            ring_mem[ch][pos] = beat.sample_mv;
            ring_wr[ch]       = pos + 8'd1;
            if (chg_phase[ch])
            begin
                if (win_sum[ch] >= {thr_charge, 8'h00})
                begin
                    chg_phase[ch] = 1'b0;
                    chg_avg[ch]   = floor_avg(chg_avg[ch], chg_count[ch]);
                    chg_count[ch] = '0;
                    flip          = 1'b1;
                end
            end
            else if (win_sum[ch] <= {thr_discharge, 8'h00})
            begin
                chg_phase[ch] = 1'b1;
                dis_avg[ch]   = floor_avg(dis_avg[ch], dis_count[ch]);
                dis_count[ch] = '0;
                flip          = 1'b1;
            end
        end
        // Unused mode and samples on an idle channel fall through with no change.
        want.channel_out   = beat.channel;
        want.is_active     = chan_on[ch];
        want.next_charging = chg_phase[ch];
        want.switched      = flip;
        want.filtered_mv   = win_sum[ch][19:8];
        want.reading       = chan_on[ch] ? floor_avg(chg_avg[ch], dis_avg[ch]) : 32'd0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic rcpt_pkg::sample_t make_beat(input logic [1:0] mode, input int ch,
                                                    input logic [11:0] smp);
        rcpt_pkg::sample_t b;
        b.mode      = mode;
        b.channel   = ch[2:0];
        b.sample_mv = smp;
        return b;
    endfunction

    // Mostly well-formed pulse trains: enable a channel from the focus range,
    // then feed readings that follow its drive level so the window crosses
    // the thresholds. The rest is noise: stray enables, disables, unused mode
    // and readings on random channels.
    function automatic rcpt_pkg::sample_t pick_beat(input int span);
        int          roll;
        int          ch;
        logic [11:0] smp;
        roll = $urandom_range(0, 99);
        ch   = $urandom_range(0, CHANNELS - 1);
        smp  = $urandom_range(0, 4095);
        if (roll < 4)
            return make_beat(rcpt_pkg::MODE_ENABLE, ch, smp);
        if (roll < 6)
            return make_beat(rcpt_pkg::MODE_DISABLE, ch, smp);
        if (roll < 8)
            return make_beat(MODE_UNUSED, ch, smp);
        if (roll < 11)
            return make_beat(rcpt_pkg::MODE_SAMPLE, ch, smp);
        ch = $urandom_range(0, span);
        if (!chan_on[ch])
            return make_beat(rcpt_pkg::MODE_ENABLE, ch, smp);
        if ($urandom_range(0, 9) != 0)
            smp = chg_phase[ch] ? 12'($urandom_range(2048, 4095))
                                : 12'($urandom_range(0, 2047));
        return make_beat(rcpt_pkg::MODE_SAMPLE, ch, smp);
    endfunction

    // Offer one beat, with a random gap first unless calm, and hold it until
    // taken. Valid stays high into the next beat when no gap follows.
    task automatic send_beat(input rcpt_pkg::sample_t beat);
        rcpt_pkg::result_t want;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= beat;
        do
            @(posedge clk);
        while (!sample_ready);
        track_channel(beat, want);
        pending_results.push_back(want);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_for_results();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the block takes it at the
    // edge that ends the access cycle. The bus is left idle before it returns.
    task automatic write_threshold(input logic [0:0] idx, input logic [11:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {20'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == rcpt_pkg::REG_CHARGE_THR)
            thr_charge = value;
        else
            thr_discharge = value;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [11:0] charge, input logic [11:0] discharge);
        wait_for_results();
        write_threshold(rcpt_pkg::REG_CHARGE_THR, charge);
        write_threshold(rcpt_pkg::REG_DISCHARGE_THR, discharge);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Readings and stray modes on channels that were never enabled.
    task automatic test_idle_channels();
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 0, 12'hFFF));
        send_beat(make_beat(MODE_UNUSED, 5, 12'h555));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 7, 12'hAAA));
        send_beat(make_beat(rcpt_pkg::MODE_DISABLE, 2, 12'h000));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 2, 12'h800));
    endtask

    // First reading after enable ends the empty discharge phase at once;
    // then charge under the reset thresholds, poke the unused mode on a live
    // channel, and re-enable to clear it mid-phase.
    task automatic test_phase_switching();
        send_beat(make_beat(rcpt_pkg::MODE_ENABLE, 6, 12'h123));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 6, 12'h000));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 6, 12'hFFF));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 6, 12'hFFF));
        send_beat(make_beat(MODE_UNUSED, 6, 12'hFFF));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 6, 12'h7FF));
        send_beat(make_beat(rcpt_pkg::MODE_ENABLE, 6, 12'h000));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 6, 12'h001));
    endtask

    // Threshold extremes: zero charge with full discharge flips the phase on
    // every reading; full charge with zero discharge pins it in charging.
    task automatic test_threshold_extremes();
        set_thresholds(12'd0, 12'd4095);
        send_beat(make_beat(rcpt_pkg::MODE_ENABLE, 1, 12'h000));
        repeat (4) send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 1, 12'hFFF));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 1, 12'h000));
        set_thresholds(12'd4095, 12'd0);
        send_beat(make_beat(rcpt_pkg::MODE_ENABLE, 1, 12'h000));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 1, 12'h000));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 1, 12'hFFF));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 1, 12'hFFF));
        send_beat(make_beat(rcpt_pkg::MODE_DISABLE, 1, 12'hFFF));
        send_beat(make_beat(rcpt_pkg::MODE_SAMPLE, 1, 12'hFFF));
    endtask

    // Hold the receiver off while the sender keeps offering beats back to
    // back, so the output register fills and the input stalls; then pause the
    // sender until every result is home.
    task automatic test_backpressure();
        set_thresholds(12'd30, 12'd10);
        calm          = 1'b1;
        stall_request = 1'b1;
        repeat (24) send_beat(pick_beat(0));
        calm = 1'b0;
        wait_for_results();
    endtask

    // Phases of random pulse trains under several threshold settings.
    task automatic test_random_traffic();
        int charge;
        set_thresholds(rcpt_pkg::CHARGE_THR_RST, rcpt_pkg::DISCHARGE_THR_RST);
        repeat (200) send_beat(pick_beat(0));
        set_thresholds(12'd40, 12'd10);
        repeat (200) send_beat(pick_beat(CHANNELS - 1));
        set_thresholds(12'd4095, 12'd0);
        repeat (150) send_beat(pick_beat(3));
        set_thresholds(12'd0, 12'd4095);
        repeat (150) send_beat(pick_beat(CHANNELS - 1));
        charge = $urandom_range(8, 200);
        set_thresholds(12'(charge), 12'($urandom_range(0, charge)));
        repeat (200) send_beat(pick_beat(3));
    endtask

    // Final stretch with no idling on either side and arbitrary thresholds.
    task automatic test_steady_stream();
        set_thresholds(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        calm = 1'b1;
        repeat (250) send_beat(pick_beat(CHANNELS - 1));
    endtask

    // ------------------------------------------------------------------
    // Result sink: random hold-off bursts, or one long hold on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                result_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                stall_request = 1'b0;
                result_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each taken beat with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rcpt_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing predicted, channel_out %0d",
                       result.channel_out);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("channel_out",   want.channel_out,   result.channel_out);
                check_field("is_active",     want.is_active,     result.is_active);
                check_field("next_charging", want.next_charging, result.next_charging);
                check_field("switched",      want.switched,      result.switched);
                check_field("filtered_mv",   want.filtered_mv,   result.filtered_mv);
                check_field("reading",       want.reading,       result.reading);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any beat or register write counts as progress
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
                (psel && penable && pwrite))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("rc_pulse_adc_channel_tracker_unit: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
            wipe_channel(ch);
        thr_charge    = rcpt_pkg::CHARGE_THR_RST;
        thr_discharge = rcpt_pkg::DISCHARGE_THR_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_channels();
        test_phase_switching();
        test_threshold_extremes();
        test_backpressure();
        test_random_traffic();
        test_steady_stream();

        wait_for_results();
        if (fail_count == 0)
            $display("rc_pulse_adc_channel_tracker_unit: match");
        else
            $display("rc_pulse_adc_channel_tracker_unit: mismatch");
        $finish;
    end

endmodule
